// ----- hw/rtl/spl_pkg.sv -----
// Shared types, constants and helpers for the stereo peak level meter.
`default_nettype none

package spl_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int MAG_W         = 15;
  localparam int COUNT_FIELD_W = 32;
  localparam int COUNT_WIDTH   = 32;
  localparam int CFG_INDEX_W   = 8;
  localparam int CFG_DATA_W    = 16;

  localparam logic [MAG_W-1:0] THR_HALF_RESET        = 15'd16383;
  localparam logic [MAG_W-1:0] THR_NINETY_RESET      = 15'd29490;
  localparam logic [MAG_W-1:0] THR_NINETY_NINE_RESET = 15'd32439;
  localparam logic [MAG_W-1:0] THR_CLIP_RESET        = 15'd32764;

  localparam logic [CFG_INDEX_W-1:0] REG_HALF        = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NINETY      = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NINETY_NINE = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLIP        = 8'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       block_end;
  } in_item_t;

  typedef struct packed {
    logic [MAG_W-1:0]         peak_left;
    logic [MAG_W-1:0]         peak_right;
    logic                     block_done;
    logic [COUNT_FIELD_W-1:0] count_above_half;
    logic [COUNT_FIELD_W-1:0] count_above_ninety;
    logic [COUNT_FIELD_W-1:0] count_above_ninety_nine;
    logic [COUNT_FIELD_W-1:0] count_clipped;
  } out_item_t;

  typedef struct packed {
    logic [MAG_W-1:0] half;
    logic [MAG_W-1:0] ninety;
    logic [MAG_W-1:0] ninety_nine;
    logic [MAG_W-1:0] clip;
  } thr_t;

  // Magnitude of a two's complement sample; the most negative code saturates.
  function automatic logic [MAG_W-1:0] magnitude(input logic signed [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] neg;
    neg = SAMPLE_W'(-s);
    if (s == {1'b1, {(SAMPLE_W-1){1'b0}}}) begin
      magnitude = {MAG_W{1'b1}};
    end else if (s[SAMPLE_W-1]) begin
      magnitude = neg[MAG_W-1:0];
    end else begin
      magnitude = s[MAG_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/spl_regs.sv -----
// Threshold register file written through the configuration port.
`default_nettype none

module spl_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [spl_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [spl_pkg::CFG_DATA_W-1:0]     cfg_data,
  output spl_pkg::thr_t                           thr
);
  import spl_pkg::*;

  logic [MAG_W-1:0] value;

  assign cfg_ready = 1'b1;
  assign value     = cfg_data[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      thr.half        <= THR_HALF_RESET;
      thr.ninety      <= THR_NINETY_RESET;
      thr.ninety_nine <= THR_NINETY_NINE_RESET;
      thr.clip        <= THR_CLIP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      // Writes to indexes past the last register are dropped.
      case (cfg_index)
        REG_HALF:        thr.half        <= value;
        REG_NINETY:      thr.ninety      <= value;
        REG_NINETY_NINE: thr.ninety_nine <= value;
        REG_CLIP:        thr.clip        <= value;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/spl_sat_counter.sv -----
// Saturating event counter that presents its updated value in the same cycle.
`default_nettype none

module spl_sat_counter #(
  parameter int COUNT_WIDTH = spl_pkg::COUNT_WIDTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                hit,
  output logic [spl_pkg::COUNT_FIELD_W-1:0]        field
);
  import spl_pkg::*;

  localparam int ExtWidth = (COUNT_WIDTH > COUNT_FIELD_W) ? COUNT_WIDTH : COUNT_FIELD_W;

  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] cnt_next;
  logic [ExtWidth-1:0]    ext;

  assign cnt_next = (hit && !(&cnt)) ? cnt + COUNT_WIDTH'(1) : cnt;
  assign ext      = ExtWidth'(cnt_next);
  assign field    = ext[COUNT_FIELD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (en) begin
      cnt <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/stereo_peak_level_meter.sv -----
// Top level of the stereo peak level meter: input stage, peak tracking and result stage.
// An accepted frame passes through the input register and then the result register,
// where magnitude, peaks and counts are formed.
// Throughput: one frame per cycle; the result register is the only point of back-pressure.
// Reset (synchronous, rst high): peaks and counters clear, thresholds load their
// defaults, both pipeline stages empty. No clearing pass is needed.
`default_nettype none

module stereo_peak_level_meter #(
  parameter int COUNT_WIDTH = spl_pkg::COUNT_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            sample_valid,
  output logic                                 sample_stall,
  input  wire spl_pkg::in_item_t               sample,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output spl_pkg::out_item_t                   result,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [spl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [spl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import spl_pkg::*;

  thr_t             thr;
  logic             s1_valid;
  in_item_t         s1_item;
  logic             advance;
  logic             accept;
  logic [MAG_W-1:0] mag_l;
  logic [MAG_W-1:0] mag_r;
  logic [MAG_W-1:0] run_l;
  logic [MAG_W-1:0] run_r;
  logic [MAG_W-1:0] peak_l;
  logic [MAG_W-1:0] peak_r;
  logic             hit_half;
  logic             hit_ninety;
  logic             hit_ninety_nine;
  logic             hit_clip;
  out_item_t        result_next;

  spl_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thr       (thr)
  );

  // The result stage moves whenever its register is empty or being taken.
  assign advance      = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = s1_valid && result_valid && result_stall;
  assign accept       = sample_valid && !sample_stall;

  assign mag_l  = magnitude(s1_item.left_sample);
  assign mag_r  = magnitude(s1_item.right_sample);
  assign peak_l = (mag_l > run_l) ? mag_l : run_l;
  assign peak_r = (mag_r > run_r) ? mag_r : run_r;

  assign hit_half        = (mag_l > thr.half)        || (mag_r > thr.half);
  assign hit_ninety      = (mag_l > thr.ninety)      || (mag_r > thr.ninety);
  assign hit_ninety_nine = (mag_l > thr.ninety_nine) || (mag_r > thr.ninety_nine);
  assign hit_clip        = (mag_l > thr.clip)        || (mag_r > thr.clip);

  spl_sat_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_cnt_half (
    .clk (clk), .rst (rst), .en (advance), .hit (hit_half),
    .field (result_next.count_above_half)
  );

  spl_sat_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_cnt_ninety (
    .clk (clk), .rst (rst), .en (advance), .hit (hit_ninety),
    .field (result_next.count_above_ninety)
  );

  spl_sat_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_cnt_ninety_nine (
    .clk (clk), .rst (rst), .en (advance), .hit (hit_ninety_nine),
    .field (result_next.count_above_ninety_nine)
  );

  spl_sat_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_cnt_clip (
    .clk (clk), .rst (rst), .en (advance), .hit (hit_clip),
    .field (result_next.count_clipped)
  );

  assign result_next.peak_left  = peak_l;
  assign result_next.peak_right = peak_r;
  assign result_next.block_done = s1_item.block_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      run_l        <= '0;
      run_r        <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
        // The peaks restart after the frame that closes a block.
        run_l <= s1_item.block_end ? '0 : peak_l;
        run_r <= s1_item.block_end ? '0 : peak_r;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= sample;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  a_peak_restart: assert property (@(posedge clk) disable iff (rst)
    advance && s1_item.block_end |=> run_l == '0 && run_r == '0)
    else $error("running peaks not cleared after block end");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> result_valid && result.block_done == $past(s1_item.block_end))
    else $error("result register not loaded from input stage");

  a_peak_covers_frame: assert property (@(posedge clk) disable iff (rst)
    advance |=> result.peak_left >= $past(mag_l) && result.peak_right >= $past(mag_r))
    else $error("reported peak below frame magnitude");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the stereo peak level meter: directed and random frames.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spl_pkg::*;

  localparam int LIMIT_CYCLES      = 200000;
  localparam int FRAMES_PER_PHASE  = 205;
  localparam int PHASES            = 7;
  localparam int SETTLE_CYCLES     = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_BEYOND = 8'd4;

  typedef struct packed {
    in_item_t  frame;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  in_item_t               sample = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  out_item_t              result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow of the meter: thresholds, running peaks and the four counters.
  thr_t                   thr;
  logic [MAG_W-1:0]       peak_l, peak_r;
  logic [COUNT_WIDTH-1:0] cnt_half, cnt_ninety, cnt_ninety_nine, cnt_clip;

  out_item_t   pending_results [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          steady = 1'b0;
  dir_row_t    directed_rows [20];

  stereo_peak_level_meter DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= !steady && ($urandom_range(99) < 30);
    end
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Result checker: every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with no frame pending");
      end else begin
        want = pending_results.pop_front();
        compare_field("peak_left", 32'(result.peak_left), 32'(want.peak_left));
        compare_field("peak_right", 32'(result.peak_right), 32'(want.peak_right));
        compare_field("block_done", 32'(result.block_done), 32'(want.block_done));
        compare_field("count_above_half", result.count_above_half,
                      want.count_above_half);
        compare_field("count_above_ninety", result.count_above_ninety,
                      want.count_above_ninety);
        compare_field("count_above_ninety_nine", result.count_above_ninety_nine,
                      want.count_above_ninety_nine);
        compare_field("count_clipped", result.count_clipped, want.count_clipped);
      end
    end
  end

  function automatic logic [MAG_W-1:0] level_of(logic [SAMPLE_W-1:0] raw);
    logic [SAMPLE_W:0] m;
    if (!raw[SAMPLE_W-1]) begin
      return raw[MAG_W-1:0];
    end
    m = 17'h10000 - {1'b0, raw};
    return (m > 17'd32767) ? 15'h7FFF : m[MAG_W-1:0];
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] c, logic hit);
    return (hit && c != '1) ? c + 1'b1 : c;
  endfunction

  function automatic out_item_t predict_frame(in_item_t f);
    out_item_t        o;
    logic [MAG_W-1:0] ml, mr;
    ml = level_of(f.left_sample);
    mr = level_of(f.right_sample);
    if (ml > peak_l) peak_l = ml;
    if (mr > peak_r) peak_r = mr;
    cnt_half        = sat_inc(cnt_half, ml > thr.half || mr > thr.half);
    cnt_ninety      = sat_inc(cnt_ninety, ml > thr.ninety || mr > thr.ninety);
    cnt_ninety_nine = sat_inc(cnt_ninety_nine,
                              ml > thr.ninety_nine || mr > thr.ninety_nine);
    cnt_clip        = sat_inc(cnt_clip, ml > thr.clip || mr > thr.clip);
    o.peak_left               = peak_l;
    o.peak_right              = peak_r;
    o.block_done              = f.block_end;
    o.count_above_half        = COUNT_FIELD_W'(cnt_half);
    o.count_above_ninety      = COUNT_FIELD_W'(cnt_ninety);
    o.count_above_ninety_nine = COUNT_FIELD_W'(cnt_ninety_nine);
    o.count_clipped           = COUNT_FIELD_W'(cnt_clip);
    if (f.block_end) begin
      peak_l = '0;
      peak_r = '0;
    end
    return o;
  endfunction

  function automatic dir_row_t frame_row(logic signed [SAMPLE_W-1:0] l,
                                         logic signed [SAMPLE_W-1:0] r, logic e);
    dir_row_t row;
    row.frame = '{left_sample: l, right_sample: r, block_end: e};
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic dir_row_t typed_row(logic signed [SAMPLE_W-1:0] l,
                                         logic signed [SAMPLE_W-1:0] r, logic e,
                                         logic [MAG_W-1:0] pl, logic [MAG_W-1:0] pr,
                                         logic [31:0] h, logic [31:0] n,
                                         logic [31:0] nn, logic [31:0] c);
    dir_row_t row;
    row = frame_row(l, r, e);
    row.typed = 1'b1;
    row.want  = '{peak_left: pl, peak_right: pr, block_done: e, count_above_half: h,
                  count_above_ninety: n, count_above_ninety_nine: nn, count_clipped: c};
    return row;
  endfunction

  // Random codes, with a good share of full scale, near-zero values and values around a threshold.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] m;
    logic [MAG_W-1:0]    t;
    case ($urandom_range(9))
      0: m = 16'h8000;
      1: m = 16'h7FFF;
      2: m = 16'h8001;
      3: m = 16'($urandom_range(3));
      4, 5: begin
        case ($urandom_range(3))
          0: t = thr.half;
          1: t = thr.ninety;
          2: t = thr.ninety_nine;
          default: t = thr.clip;
        endcase
        m = 16'({1'b0, t} + 16'($urandom_range(2)) - 16'd1);
      end
      default: m = 16'($urandom);
    endcase
    if (m != 16'h8000 && $urandom_range(1) == 1) begin
      m = 16'(-m);
    end
    return m;
  endfunction

  task automatic send_frame(in_item_t f, logic typed, out_item_t want);
    out_item_t predicted;
    while (!steady && $urandom_range(99) < 30) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample       <= f;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    predicted = predict_frame(f);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Leaves valid high so that back-to-back writes follow without valid dropping in between.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HALF:        thr.half        = data[MAG_W-1:0];
      REG_NINETY:      thr.ninety      = data[MAG_W-1:0];
      REG_NINETY_NINE: thr.ninety_nine = data[MAG_W-1:0];
      REG_CLIP:        thr.clip        = data[MAG_W-1:0];
      default: ;
    endcase
  endtask

  // Bit 15 of the data is random to exercise truncation; two out-of-range writes follow
  // the real ones and must leave the thresholds alone.
  task automatic program_thresholds(thr_t t);
    write_reg(REG_HALF, {1'($urandom_range(1)), t.half});
    write_reg(REG_NINETY, {1'($urandom_range(1)), t.ninety});
    write_reg(REG_NINETY_NINE, {1'($urandom_range(1)), t.ninety_nine});
    write_reg(REG_CLIP, {1'($urandom_range(1)), t.clip});
    write_reg(REG_BEYOND + CFG_INDEX_W'($urandom_range(251)), 16'($urandom));
    write_reg(8'hFF, 16'h0000);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle(int extra);
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  initial begin
    thr_t     next_thr;
    in_item_t f;
    thr = '{half: THR_HALF_RESET, ninety: THR_NINETY_RESET,
            ninety_nine: THR_NINETY_NINE_RESET, clip: THR_CLIP_RESET};
    peak_l = '0;
    peak_r = '0;
    cnt_half = '0;
    cnt_ninety = '0;
    cnt_ninety_nine = '0;
    cnt_clip = '0;

    // Expected values of the first rows follow from the reset thresholds.
    directed_rows = '{
      typed_row(16'sd0, 16'sd0, 1'b0, 15'd0, 15'd0, 32'd0, 32'd0, 32'd0, 32'd0),
      typed_row(16'sh8000, 16'sd0, 1'b0, 15'd32767, 15'd0, 32'd1, 32'd1, 32'd1, 32'd1),
      typed_row(16'sd0, 16'sd32767, 1'b1, 15'd32767, 15'd32767,
                32'd2, 32'd2, 32'd2, 32'd2),
      typed_row(16'sd0, 16'sd0, 1'b1, 15'd0, 15'd0, 32'd2, 32'd2, 32'd2, 32'd2),
      typed_row(16'sd16383, -16'sd16383, 1'b0, 15'd16383, 15'd16383,
                32'd2, 32'd2, 32'd2, 32'd2),
      typed_row(16'sd16384, 16'sd0, 1'b1, 15'd16384, 15'd16383,
                32'd3, 32'd2, 32'd2, 32'd2),
      typed_row(-16'sd1, 16'sd1, 1'b0, 15'd1, 15'd1, 32'd3, 32'd2, 32'd2, 32'd2),
      frame_row(16'sd29490, 16'sd29491, 1'b0),
      frame_row(-16'sd29491, -16'sd29490, 1'b0),
      frame_row(16'sd32439, -16'sd32440, 1'b0),
      frame_row(16'sd32440, 16'sd32439, 1'b1),
      frame_row(16'sd32764, -16'sd32764, 1'b0),
      frame_row(-16'sd32765, 16'sd32765, 1'b0),
      frame_row(-16'sd32767, 16'sh8000, 1'b1),
      frame_row(16'sh5555, 16'shAAAA, 1'b0),
      frame_row(16'shAAAA, 16'sh5555, 1'b1),
      frame_row(16'sh8000, 16'sh8000, 1'b1),
      frame_row(16'sd32767, 16'sd32767, 1'b0),
      frame_row(16'sd1, 16'sh8000, 1'b1),
      frame_row(16'sd0, 16'sd0, 1'b0)
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        case (phase)
          1: next_thr = '{half: 15'd0, ninety: 15'd0, ninety_nine: 15'd0, clip: 15'd0};
          2: next_thr = '{half: 15'h7FFF, ninety: 15'h7FFF, ninety_nine: 15'h7FFF,
                          clip: 15'h7FFF};
          3: next_thr = '{half: 15'd32000, ninety: 15'd20000, ninety_nine: 15'd10000,
                          clip: 15'd100};
          6: next_thr = '{half: THR_HALF_RESET, ninety: THR_NINETY_RESET,
                          ninety_nine: THR_NINETY_NINE_RESET, clip: THR_CLIP_RESET};
          default: next_thr = '{half: 15'($urandom), ninety: 15'($urandom),
                                ninety_nine: 15'($urandom), clip: 15'($urandom)};
        endcase
        settle(SETTLE_CYCLES);
        program_thresholds(next_thr);
      end
      // The full-scale phase also runs with neither side idling.
      steady = (phase == 2);
      if (phase == 0) begin
        foreach (directed_rows[i]) begin
          send_frame(directed_rows[i].frame, directed_rows[i].typed, directed_rows[i].want);
        end
      end
      repeat (FRAMES_PER_PHASE) begin
        f.left_sample  = pick_sample();
        f.right_sample = pick_sample();
        f.block_end    = ($urandom_range(7) == 0);
        send_frame(f, 1'b0, '0);
      end
    end

    steady = 1'b0;
    settle(3 * SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
